// ===== hw/rtl/prd_pkg.sv =====
// Package for the property record deframer: codes, result type, helpers.
`default_nettype none
package prd_pkg;

	typedef enum logic [1:0] {
		PH_KIND = 2'd0,
		PH_ID   = 2'd1,
		PH_VAR  = 2'd2,
		PH_PAY  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		CLS_UNSIGNED = 3'd0,
		CLS_SIGNED   = 3'd1,
		CLS_STRING   = 3'd2,
		CLS_BLOB     = 3'd3,
		CLS_UNKNOWN  = 3'd4
	} kind_class_t;

	localparam logic [1:0] CFG_UNSIGNED = 2'd0;
	localparam logic [1:0] CFG_SIGNED   = 2'd1;
	localparam logic [1:0] CFG_STRING   = 2'd2;
	localparam logic [1:0] CFG_BLOB     = 2'd3;

	localparam logic [7:0] CHUNK_MASK = 8'h7F;
	localparam logic [7:0] CONT_BIT   = 8'h80;
	localparam logic [5:0] SHIFT_STEP = 6'd7;
	localparam logic [5:0] SHIFT_CAP  = 6'd35;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]  kind_class;
		logic [7:0]  raw_kind;
		logic [31:0] prop_id;
		logic [31:0] value;
		logic        is_payload;
		logic [7:0]  payload_byte;
		logic        record_last;
		logic [31:0] record_bytes;
		logic        overlong;
		logic        write_protect;
	} result_t;

	function automatic logic [31:0] zz_unfold(input logic [31:0] a);
		zz_unfold = (a >> 1) ^ {32{a[0]}};
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/property_record_deframer_top.sv =====
// Property record deframer: takes one stream byte per item and parses
// kind / id / varint / payload records. The parse state updates at the
// accepting edge and any result lands in an output register, so a new byte
// can be accepted each cycle while in_stall is low. A one-entry
// skid stage behind the output register lets the input keep moving while a
// result waits, until a second result has to be held; in_stall rises only
// when both hold a result. The kind class is fixed when the fourth id byte
// arrives, so code register writes affect only records whose id is not yet
// complete.
`default_nettype none
module property_record_deframer_top
	import prd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       kind_class,
	output logic [7:0]       raw_kind,
	output logic [31:0]      prop_id,
	output logic [31:0]      value,
	output logic             is_payload,
	output logic [7:0]       payload_byte,
	output logic             record_last,
	output logic [31:0]      record_bytes,
	output logic             overlong,
	output logic             write_protect
);

	logic [7:0] code_unsigned_q, code_signed_q, code_string_q, code_blob_q;

	phase_t      phase_q, phase_d;
	logic [7:0]  kind_q, kind_d;
	logic [31:0] id_q, id_d;
	logic [1:0]  id_idx_q, id_idx_d;
	logic [31:0] accum_q, accum_d;
	logic [5:0]  shift_q, shift_d;
	logic        ovl_q, ovl_d;
	logic [31:0] left_q, left_d;
	logic [31:0] count_q, count_d;
	kind_class_t class_q, class_d;

	logic        accept;
	logic        res_valid;
	result_t     res;
	logic        out_v_q, skid_v_q;
	result_t     out_q, skid_q;

	logic [6:0]  chunk;
	logic [34:0] chunk_wide;
	logic [31:0] id_shifted;

	assign accept   = in_valid & ~in_stall;
	assign in_stall = skid_v_q;

	// Code registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_unsigned_q <= 8'd0;
			code_signed_q   <= 8'd1;
			code_string_q   <= 8'd2;
			code_blob_q     <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_UNSIGNED: code_unsigned_q <= cfg_data;
				CFG_SIGNED:   code_signed_q   <= cfg_data;
				CFG_STRING:   code_string_q   <= cfg_data;
				CFG_BLOB:     code_blob_q     <= cfg_data;
			endcase
		end
	end

	assign chunk      = data_byte[6:0] & CHUNK_MASK[6:0];
	assign chunk_wide = {28'd0, chunk} << shift_q[4:0];
	assign id_shifted = {24'd0, data_byte} << {id_idx_q, 3'b000};

	// Next parse state
	always_comb begin
		phase_d  = phase_q;
		kind_d   = kind_q;
		id_d     = id_q;
		id_idx_d = id_idx_q;
		accum_d  = accum_q;
		shift_d  = shift_q;
		ovl_d    = ovl_q;
		left_d   = left_q;
		class_d  = class_q;
		count_d  = (count_q != COUNT_MAX) ? count_q + 32'd1 : count_q;
		unique case (phase_q)
			PH_ID: begin
				id_d = id_q | id_shifted;
				if (id_idx_q != 2'd3) begin
					id_idx_d = id_idx_q + 2'd1;
				end else begin
					id_idx_d = 2'd0;
					// first matching code wins
					if (kind_q == code_unsigned_q)    class_d = CLS_UNSIGNED;
					else if (kind_q == code_signed_q) class_d = CLS_SIGNED;
					else if (kind_q == code_string_q) class_d = CLS_STRING;
					else if (kind_q == code_blob_q)   class_d = CLS_BLOB;
					else                              class_d = CLS_UNKNOWN;
					phase_d = (class_d == CLS_UNKNOWN) ? PH_KIND : PH_VAR;
				end
			end
			PH_VAR: begin
				if (shift_q < 6'd32) begin
					accum_d = accum_q | chunk_wide[31:0];
					if (chunk_wide[34:32] != 3'd0) ovl_d = 1'b1;
				end else if (chunk != 7'd0) begin
					ovl_d = 1'b1;
				end
				if (shift_q < SHIFT_CAP) shift_d = shift_q + SHIFT_STEP;
				if ((data_byte & CONT_BIT) == 8'd0) begin
					if (class_q == CLS_STRING || class_q == CLS_BLOB) begin
						left_d  = accum_d;
						phase_d = (accum_d == 32'd0) ? PH_KIND : PH_PAY;
					end else begin
						phase_d = PH_KIND;
					end
				end
			end
			PH_PAY: begin
				if (left_q != 32'd0) left_d = left_q - 32'd1;
				if (left_d == 32'd0) phase_d = PH_KIND;
			end
			default: begin
				kind_d   = data_byte;
				id_d     = 32'd0;
				id_idx_d = 2'd0;
				accum_d  = 32'd0;
				shift_d  = 6'd0;
				ovl_d    = 1'b0;
				left_d   = 32'd0;
				count_d  = 32'd1;
				phase_d  = PH_ID;
			end
		endcase
	end

	// Result for the current byte
	always_comb begin
		res_valid          = 1'b0;
		res.kind_class     = class_d;
		res.raw_kind       = kind_d;
		res.prop_id        = id_d;
		res.value          = accum_d;
		res.is_payload     = 1'b0;
		res.payload_byte   = 8'd0;
		res.record_last    = 1'b1;
		res.record_bytes   = count_d;
		res.overlong       = ovl_d;
		res.write_protect  = (class_d == CLS_BLOB);
		unique case (phase_q)
			PH_ID: begin
				res_valid = (id_idx_q == 2'd3) && (class_d == CLS_UNKNOWN);
				res.value = 32'd0;
			end
			PH_VAR: begin
				res_valid = (data_byte & CONT_BIT) == 8'd0;
				if (class_q == CLS_SIGNED) begin
					res.value = zz_unfold(accum_d);
				end else if (class_q == CLS_STRING || class_q == CLS_BLOB) begin
					res.record_last = (accum_d == 32'd0);
				end
			end
			PH_PAY: begin
				res_valid        = 1'b1;
				res.is_payload   = 1'b1;
				res.payload_byte = data_byte;
				res.record_last  = (left_d == 32'd0);
			end
			default: res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_KIND;
			kind_q   <= 8'd0;
			id_q     <= 32'd0;
			id_idx_q <= 2'd0;
			accum_q  <= 32'd0;
			shift_q  <= 6'd0;
			ovl_q    <= 1'b0;
			left_q   <= 32'd0;
			count_q  <= 32'd0;
			class_q  <= CLS_UNSIGNED;
		end else if (accept) begin
			phase_q  <= phase_d;
			kind_q   <= kind_d;
			id_q     <= id_d;
			id_idx_q <= id_idx_d;
			accum_q  <= accum_d;
			shift_q  <= shift_d;
			ovl_q    <= ovl_d;
			left_q   <= left_d;
			count_q  <= count_d;
			class_q  <= class_d;
		end
	end

	// Output register and skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !out_stall) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept & res_valid;
			end
		end else if (accept && res_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !out_stall) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (accept && res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid     = out_v_q;
	assign kind_class    = out_q.kind_class;
	assign raw_kind      = out_q.raw_kind;
	assign prop_id       = out_q.prop_id;
	assign value         = out_q.value;
	assign is_payload    = out_q.is_payload;
	assign payload_byte  = out_q.payload_byte;
	assign record_last   = out_q.record_last;
	assign record_bytes  = out_q.record_bytes;
	assign overlong      = out_q.overlong;
	assign write_protect = out_q.write_protect;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds an item while the output register is empty");

	a_no_result_on_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && phase_q == PH_KIND) |-> 1'b0)
		else $error("kind byte produced a result");

	a_payload_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.is_payload) |-> (phase_q == PH_PAY))
		else $error("payload result outside the payload phase");

	a_shift_cap: assert property (@(posedge clk) disable iff (!arst_n)
		shift_q <= SHIFT_CAP)
		else $error("varint shift passed its cap");

endmodule
`default_nettype wire
